FILE: hdl/coalescing_command_table_rr_forwarder_assert.svh
// Assertion macros for the command table forwarder.
`ifndef COALESCING_COMMAND_TABLE_RR_FORWARDER_ASSERT_SVH
`define COALESCING_COMMAND_TABLE_RR_FORWARDER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication under an active-low reset.
`define CCTF_ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define CCTF_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

`else

`define CCTF_ASSERT_IMPLIES(label, clk, rst_n, a, b, msg)
`define CCTF_ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

FILE: hdl/cctf_pkg.sv
`default_nettype none

package cctf_pkg;

	// Table geometry.
	localparam int NUM_SLOTS = 6;
	localparam int FIXED_IDS = 6;
	localparam int PTR_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Field widths.
	localparam int ID_W    = 11;
	localparam int LEN_W   = 16;
	localparam int WORD_W  = 32;

	// Packet decoding constants.
	localparam logic [LEN_W-1:0] MIN_LENGTH = 16'd13;
	localparam logic [ID_W-1:0]  TRIGGER_ID = 11'h7F0;

	// Item kinds carried on the input tuser.
	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Output register occupancy.
	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
	} ctrl_cmd_t;

	// Fixed id owned by each slot; slots past the fixed list own none.
	function automatic logic [ID_W-1:0] slot_id(input logic [4:0] idx);
		logic [ID_W-1:0] id;
		case (idx)
			5'd0: id = 11'h150;
			5'd1: id = 11'h151;
			5'd2: id = 11'h155;
			5'd3: id = 11'h156;
			5'd4: id = 11'h157;
			5'd5: id = 11'h471;
			default: id = '0;
		endcase
		return id;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/cctf_ctrl.sv
`default_nettype none

module cctf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output cctf_pkg::ctrl_cmd_t     cmd
);
	import cctf_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_next;
		end
	end

	// The result register takes a new transaction when empty or being drained.
	always_comb begin
		state_next = state_q;
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		cmd.load   = 1'b0;
		case (state_q)
			ST_EMPTY: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					state_next = ST_FULL;
				end
			end
			ST_FULL: begin
				m_tvalid = 1'b1;
				s_tready = m_tready;
				cmd.load = s_tvalid && m_tready;
				if (m_tready && !s_tvalid) begin
					state_next = ST_EMPTY;
				end
			end
			default: begin
				state_next = ST_EMPTY;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/cctf_datapath.sv
`default_nettype none

module cctf_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cctf_pkg::ctrl_cmd_t           cmd,
	input  wire logic                          command,
	input  wire logic [cctf_pkg::LEN_W-1:0]    packet_length,
	input  wire logic [cctf_pkg::WORD_W-1:0]   id_word,
	input  wire logic [cctf_pkg::WORD_W-1:0]   data_low,
	input  wire logic [cctf_pkg::WORD_W-1:0]   data_high,
	output logic                               frame_valid,
	output logic [cctf_pkg::ID_W-1:0]          frame_id,
	output logic [cctf_pkg::WORD_W-1:0]        frame_low,
	output logic [cctf_pkg::WORD_W-1:0]        frame_high,
	output logic                               frame_toggle,
	output logic                               soft_trigger,
	output logic [cctf_pkg::WORD_W-1:0]        received_count,
	output logic [cctf_pkg::WORD_W-1:0]        sent_count,
	output logic [cctf_pkg::WORD_W-1:0]        dropped_count
);
	import cctf_pkg::*;

	// Table and bookkeeping state.
	logic [WORD_W-1:0] slot_low_q  [NUM_SLOTS];
	logic [WORD_W-1:0] slot_high_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] dirty_q;
	logic [PTR_W-1:0]     ptr_q;
	logic                 toggle_q;
	logic                 trig_q;
	logic [WORD_W-1:0]    rx_q;
	logic [WORD_W-1:0]    tx_q;
	logic [WORD_W-1:0]    drop_q;

	// Result register.
	logic                 frame_valid_q;
	logic [ID_W-1:0]      frame_id_q;
	logic [WORD_W-1:0]    frame_low_q;
	logic [WORD_W-1:0]    frame_high_q;
	logic                 frame_toggle_q;
	logic                 soft_trigger_q;
	logic [WORD_W-1:0]    received_count_q;
	logic [WORD_W-1:0]    sent_count_q;
	logic [WORD_W-1:0]    dropped_count_q;

	// Decode and selection results.
	logic [ID_W-1:0]   id;
	logic              is_packet;
	logic              is_short;
	logic              is_trigger;
	logic              match_hit;
	logic [PTR_W-1:0]  match_idx;
	logic              pick_hit;
	logic [PTR_W-1:0]  pick_idx;
	logic [PTR_W:0]    cand;
	logic [PTR_W-1:0]  ptr_next;
	logic              send;

	assign id         = id_word[ID_W-1:0];
	assign is_packet  = (command == CMD_PACKET);
	assign is_short   = (packet_length < MIN_LENGTH);
	assign is_trigger = (id == TRIGGER_ID);
	assign send       = !is_packet && pick_hit;

	// Look the id up among the slots that own a fixed id.
	always_comb begin
		match_hit = 1'b0;
		match_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!match_hit && (i < FIXED_IDS) && (slot_id(5'(i)) == id)) begin
				match_hit = 1'b1;
				match_idx = PTR_W'(i);
			end
		end
	end

	// First dirty slot in rotating order from the pointer.
	always_comb begin
		pick_hit = 1'b0;
		pick_idx = '0;
		cand     = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			cand = {1'b0, ptr_q} + (PTR_W + 1)'(k);
			if (cand >= (PTR_W + 1)'(NUM_SLOTS)) begin
				cand = cand - (PTR_W + 1)'(NUM_SLOTS);
			end
			if (!pick_hit && dirty_q[cand[PTR_W-1:0]]) begin
				pick_hit = 1'b1;
				pick_idx = cand[PTR_W-1:0];
			end
		end
	end

	// Pointer moves to the slot after the one sent, wrapping.
	always_comb begin
		if (pick_idx == PTR_W'(NUM_SLOTS - 1)) begin
			ptr_next = '0;
		end else begin
			ptr_next = pick_idx + PTR_W'(1);
		end
	end

	// Control state: dirty marks, pointer, flags and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q  <= '0;
			ptr_q    <= '0;
			toggle_q <= 1'b0;
			trig_q   <= 1'b0;
			rx_q     <= '0;
			tx_q     <= '0;
			drop_q   <= '0;
		end else if (cmd.load) begin
			if (is_packet) begin
				rx_q <= rx_q + WORD_W'(1);
				if (is_short) begin
					drop_q <= drop_q + WORD_W'(1);
				end else if (is_trigger) begin
					trig_q <= |data_low[7:0];
				end else if (match_hit) begin
					dirty_q[match_idx] <= 1'b1;
				end
			end else if (pick_hit) begin
				dirty_q[pick_idx] <= 1'b0;
				toggle_q          <= !toggle_q;
				tx_q              <= tx_q + WORD_W'(1);
				ptr_q             <= ptr_next;
			end
		end
	end

	// Slot values keep the latest payload per id.
	always_ff @(posedge clk) begin
		if (cmd.load && is_packet && !is_short && !is_trigger && match_hit) begin
			slot_low_q[match_idx]  <= data_low;
			slot_high_q[match_idx] <= data_high;
		end
	end

	// Result register, loaded with the state as it stands after the item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame_valid_q    <= send;
			frame_id_q       <= send ? slot_id(5'(pick_idx)) : '0;
			frame_low_q      <= send ? slot_low_q[pick_idx] : '0;
			frame_high_q     <= send ? slot_high_q[pick_idx] : '0;
			frame_toggle_q   <= toggle_q ^ send;
			soft_trigger_q   <= (is_packet && !is_short && is_trigger) ?
				(|data_low[7:0]) : trig_q;
			received_count_q <= is_packet ? (rx_q + WORD_W'(1)) : rx_q;
			sent_count_q     <= send ? (tx_q + WORD_W'(1)) : tx_q;
			dropped_count_q  <= (is_packet && is_short) ? (drop_q + WORD_W'(1)) : drop_q;
		end
	end

	assign frame_valid    = frame_valid_q;
	assign frame_id       = frame_id_q;
	assign frame_low      = frame_low_q;
	assign frame_high     = frame_high_q;
	assign frame_toggle   = frame_toggle_q;
	assign soft_trigger   = soft_trigger_q;
	assign received_count = received_count_q;
	assign sent_count     = sent_count_q;
	assign dropped_count  = dropped_count_q;

endmodule

`default_nettype wire

FILE: hdl/coalescing_command_table_rr_forwarder.sv
//  Channel  Direction  Contents
//  s_*      in         packet or pacing tick (tuser selects which)
//  m_*      out        one result per transaction: frame, flags and counters
//
//  Each accepted transaction is loaded straight into the result register, so one
//  item per cycle is sustained while m_tready stays high; the id match and the rotating
//  pick over the dirty marks are combinational.
//  Reset clears the dirty marks, pointer, flags and counters at once.
//  While a result waits untaken, s_tready follows m_tready.
`default_nettype none

`include "coalescing_command_table_rr_forwarder_assert.svh"

module coalescing_command_table_rr_forwarder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// packet_length[15:0], id_word[47:16], data_low[79:48], data_high[111:80]
	input  wire logic [111:0] s_tdata,
	// command[0]
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// frame_id[10:0], frame_low[42:11], frame_high[74:43], frame_toggle[75],
	// soft_trigger[76], received_count[108:77], sent_count[140:109],
	// dropped_count[172:141], zero fill[175:173]
	output logic [175:0]      m_tdata,
	// frame_valid[0]
	output logic              m_tuser
);
	import cctf_pkg::*;

	ctrl_cmd_t         cmd;
	logic [ID_W-1:0]   frame_id;
	logic [WORD_W-1:0] frame_low;
	logic [WORD_W-1:0] frame_high;
	logic              frame_toggle;
	logic              soft_trigger;
	logic [WORD_W-1:0] received_count;
	logic [WORD_W-1:0] sent_count;
	logic [WORD_W-1:0] dropped_count;

	// Handshake controller.
	cctf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Table, arbiter and result register.
	cctf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.command        (s_tuser),
		.packet_length  (s_tdata[15:0]),
		.id_word        (s_tdata[47:16]),
		.data_low       (s_tdata[79:48]),
		.data_high      (s_tdata[111:80]),
		.frame_valid    (m_tuser),
		.frame_id       (frame_id),
		.frame_low      (frame_low),
		.frame_high     (frame_high),
		.frame_toggle   (frame_toggle),
		.soft_trigger   (soft_trigger),
		.received_count (received_count),
		.sent_count     (sent_count),
		.dropped_count  (dropped_count)
	);

	// Pack the result fields, lowest first.
	assign m_tdata = {3'b000, dropped_count, sent_count, received_count, soft_trigger,
		frame_toggle, frame_high, frame_low, frame_id};

	// A pending result blocks new input unless it is taken in the same cycle.
	`CCTF_ASSERT_IMPLIES(a_hold_blocks_input, clk, arst_n, m_tvalid && !m_tready, !s_tready, "input accepted while result stalled")
	// Every accepted transaction leaves a result in the register.
	`CCTF_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, s_tvalid && s_tready, m_tvalid, "accepted transaction produced no result")
	// A received packet never forwards a frame.
	`CCTF_ASSERT_NEXT(a_packet_no_frame, clk, arst_n, s_tvalid && s_tready && (s_tuser == CMD_PACKET), !m_tuser, "packet forwarded a frame")

endmodule

`default_nettype wire
